// ===== rtl/core/great_circle_initial_bearing_assert.svh =====
// Assertion macros used by the checker module gcib_checker.
`ifndef GREAT_CIRCLE_INITIAL_BEARING_ASSERT_SVH
`define GREAT_CIRCLE_INITIAL_BEARING_ASSERT_SVH

// Same-cycle implication.
`define GCIB_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("gcib: check failed");

// Implication after a fixed delay.
`define GCIB_ASSERT_DLY(lbl, ck, rn, ante, dly, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##dly (cons)) \
        else $error("gcib: latency check failed");

`endif

// ===== rtl/core/gcib_pkg.sv =====
package gcib_pkg;

    localparam int FRAC_BITS_DEF    = 22;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int GUARD_BITS       = 6;
    localparam int TRIG_BITS        = 30;
    // CORDIC datapath width and trig operand width
    localparam int XW               = 36;
    localparam int TW               = 32;
    localparam longint GAIN_Q30     = 652032874;
    localparam longint unsigned NANO = 64'd1000000000;

    // atan(2^-i) in units of 1e-9 degree
    localparam longint unsigned ATAN_NANO [32] = '{
        64'd45000000000, 64'd26565051177, 64'd14036243468, 64'd7125016349,
        64'd3576334375,  64'd1789910608,  64'd895173710,   64'd447614171,
        64'd223810500,   64'd111905677,   64'd55952892,    64'd27976453,
        64'd13988227,    64'd6994114,     64'd3497057,     64'd1748528,
        64'd874264,      64'd437132,      64'd218566,      64'd109283,
        64'd54642,       64'd27321,       64'd13660,       64'd6830,
        64'd3415,        64'd1708,        64'd854,         64'd427,
        64'd213,         64'd107,         64'd53,          64'd27
    };

    typedef struct packed {
        logic valid;
        logic flip;
        logic spec;
    } tag_t;

endpackage

// ===== rtl/core/gcib_cordic_cell.sv =====
module gcib_cordic_cell #(
    parameter int FRAC_BITS = 22,
    parameter int ZW        = 38,
    parameter int STAGE     = 0,
    parameter bit VECTOR    = 1'b0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gcib_pkg::tag_t                tag_in,
    input  logic signed [gcib_pkg::XW-1:0] x_in,
    input  logic signed [gcib_pkg::XW-1:0] y_in,
    input  logic signed [ZW-1:0]          z_in,
    output gcib_pkg::tag_t                tag_out,
    output logic signed [gcib_pkg::XW-1:0] x_out,
    output logic signed [gcib_pkg::XW-1:0] y_out,
    output logic signed [ZW-1:0]          z_out
);
    import gcib_pkg::*;

    localparam int ANG_BITS = FRAC_BITS + GUARD_BITS;
    localparam longint unsigned NV = ATAN_NANO[STAGE % 32];
    localparam longint unsigned DA_U = ((NV / NANO) << ANG_BITS)
                                     + (((NV % NANO) << ANG_BITS) + NANO / 2) / NANO;
    localparam logic signed [ZW-1:0] DA = ZW'(DA_U);

    tag_t                 tag_reg;
    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 up;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        up = VECTOR ? (y_in >= 0) : (z_in >= 0);
        if (VECTOR ? up : !up)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + DA;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - DA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else
            tag_reg <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign tag_out = tag_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

// ===== rtl/core/great_circle_initial_bearing.sv =====
// Channel   Direction  Ports                                    Handshake
// request   in         start_lat start_lon end_lat end_lon      start / busy
// result    out        bearing                                  done (strobe)
//
// Fully pipelined: one request per cycle; busy is always low.
// The pipeline holds two CORDIC sections: sin/cos rotation, then atan2 vectoring.
// rst_n clears all valid flags asynchronously; data registers are not reset.
// The receiver cannot stall; done is high for one cycle per request.
module great_circle_initial_bearing #(
    parameter int FRAC_BITS    = gcib_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = gcib_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [29:0] start_lat,
    input  logic signed [30:0] start_lon,
    input  logic signed [29:0] end_lat,
    input  logic signed [30:0] end_lon,
    output logic               done,
    output logic        [30:0] bearing
);
    import gcib_pkg::*;

    localparam int ANG_BITS = FRAC_BITS + GUARD_BITS;
    localparam int ZW       = ANG_BITS + 10;
    localparam int S        = CORDIC_STEPS;
    localparam logic signed [ZW-1:0] QUARTER  = ZW'(longint'(90) << ANG_BITS);
    localparam logic signed [ZW-1:0] HALF     = ZW'(longint'(180) << ANG_BITS);
    localparam logic signed [ZW-1:0] FULL     = ZW'(longint'(360) << ANG_BITS);
    localparam logic signed [ZW-1:0] FULL_OUT = ZW'(longint'(360) << FRAC_BITS);
    localparam logic signed [ZW-1:0] RND      = ZW'(longint'(1) << (GUARD_BITS - 1));

    // Q.TRIG_BITS product, rounded half up
    function automatic logic signed [TW-1:0] mulq(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] p;
        p = a * b;
        p = p + (2*TW)'(longint'(1) << (TRIG_BITS - 1));
        return TW'(p >>> TRIG_BITS);
    endfunction

    assign busy = 1'b0;

    // ---- stage 0: scale to Q.ANG_BITS, wrap longitude difference --------
    logic                 s0_valid_reg, s0_coinc_reg;
    logic signed [ZW-1:0] s0_a_reg [3];
    logic signed [ZW-1:0] dl_scaled, dl_next;
    logic signed [31:0]   dlon;

    always_comb
    begin
        dlon      = 32'(end_lon) - 32'(start_lon);
        dl_scaled = ZW'(dlon) <<< GUARD_BITS;
        if (dl_scaled >= HALF)
            dl_next = dl_scaled - FULL;
        else if (dl_scaled < -HALF)
            dl_next = dl_scaled + FULL;
        else
            dl_next = dl_scaled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s0_coinc_reg <= (start_lat == end_lat) && (start_lon == end_lon);
        s0_a_reg[0]  <= ZW'(start_lat) <<< GUARD_BITS;
        s0_a_reg[1]  <= ZW'(end_lat) <<< GUARD_BITS;
        s0_a_reg[2]  <= dl_next;
    end

    // ---- stage 1: fold into [-90, 90], remember the half-turn ----------
    tag_t                 s1_tag_reg [3];
    logic signed [ZW-1:0] s1_z_reg [3];
    logic signed [ZW-1:0] fz_next [3];
    logic                 ff_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ff_next[k] = 1'b1;
            if (s0_a_reg[k] > QUARTER)
                fz_next[k] = s0_a_reg[k] - HALF;
            else if (s0_a_reg[k] < -QUARTER)
                fz_next[k] = s0_a_reg[k] + HALF;
            else
            begin
                fz_next[k] = s0_a_reg[k];
                ff_next[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int k = 0; k < 3; k++)
                s1_tag_reg[k] <= '0;
        else
            for (int k = 0; k < 3; k++)
                s1_tag_reg[k] <= '{valid: s0_valid_reg, flip: ff_next[k],
                                   spec: (k == 0) ? s0_coinc_reg : 1'b0};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            s1_z_reg[k] <= fz_next[k];
    end

    // ---- rotation chains: sin/cos of lat1, lat2, dLon -------------------
    tag_t                 rt [3][S+1];
    logic signed [XW-1:0] rx [3][S+1];
    logic signed [XW-1:0] ry [3][S+1];
    logic signed [ZW-1:0] rz [3][S+1];

    for (genvar c = 0; c < 3; c++)
    begin : g_rot
        assign rt[c][0] = s1_tag_reg[c];
        assign rx[c][0] = XW'(GAIN_Q30);
        assign ry[c][0] = '0;
        assign rz[c][0] = s1_z_reg[c];
        for (genvar i = 0; i < S; i++)
        begin : g_cell
            gcib_cordic_cell #(
                .FRAC_BITS(FRAC_BITS), .ZW(ZW), .STAGE(i), .VECTOR(1'b0)
            ) u_cell (
                .clk(clk), .rst_n(rst_n),
                .tag_in(rt[c][i]), .x_in(rx[c][i]), .y_in(ry[c][i]), .z_in(rz[c][i]),
                .tag_out(rt[c][i+1]), .x_out(rx[c][i+1]), .y_out(ry[c][i+1]),
                .z_out(rz[c][i+1])
            );
        end
    end

    // ---- sign restore: sin and cos of each angle -----------------------
    logic                 sc_valid_reg, sc_spec_reg;
    logic signed [TW-1:0] sn_reg [3];
    logic signed [TW-1:0] cs_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_valid_reg <= 1'b0;
        else
            sc_valid_reg <= rt[0][S].valid;
    end

    always_ff @(posedge clk)
    begin
        sc_spec_reg <= rt[0][S].spec;
        for (int k = 0; k < 3; k++)
        begin
            sn_reg[k] <= rt[k][S].flip ? TW'(-ry[k][S]) : TW'(ry[k][S]);
            cs_reg[k] <= rt[k][S].flip ? TW'(-rx[k][S]) : TW'(rx[k][S]);
        end
    end

    // ---- products ------------------------------------------------------
    // index 0: lat1, 1: lat2, 2: dLon
    logic                 m1_valid_reg, m1_spec_reg, m2_valid_reg, m2_spec_reg;
    logic signed [TW-1:0] m1_p1_reg, m1_a_reg, m1_b_reg, m1_cd_reg, m2_p1_reg;
    logic signed [TW:0]   m2_p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= sc_valid_reg;
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_spec_reg <= sc_spec_reg;
        m1_p1_reg   <= mulq(sn_reg[2], cs_reg[1]);
        m1_a_reg    <= mulq(cs_reg[0], sn_reg[1]);
        m1_b_reg    <= mulq(sn_reg[0], cs_reg[1]);
        m1_cd_reg   <= cs_reg[2];
        m2_spec_reg <= m1_spec_reg;
        m2_p1_reg   <= m1_p1_reg;
        m2_p2_reg   <= (TW+1)'(m1_a_reg) - (TW+1)'(mulq(m1_b_reg, m1_cd_reg));
    end

    // ---- vectoring set-up: half-plane fold, normalise, shift ----------
    logic                 v0_valid_reg, v1_valid_reg, v2_valid_reg;
    logic                 v0_spec_reg, v1_spec_reg, v2_spec_reg;
    logic signed [XW-1:0] v0_x_reg, v0_y_reg, v1_x_reg, v1_y_reg, v2_x_reg, v2_y_reg;
    logic signed [ZW-1:0] v0_z_reg, v1_z_reg, v2_z_reg;
    logic        [5:0]    v1_sh_reg, sh_next;
    logic                 neg_next;
    logic        [31:0]   cont;

    assign neg_next = m2_p2_reg < 0;

    always_comb
    begin
        logic signed [XW-1:0] lim;
        lim = '0;
        for (int k = 0; k < 32; k++)
        begin
            if (k <= 29)
            begin
                lim     = XW'(longint'(1) << (29 - k));
                cont[k] = (v0_x_reg < lim) && (v0_y_reg < lim) && (v0_y_reg > -lim);
            end
            else
                cont[k] = (v0_x_reg == 0) && (v0_y_reg == 0);
        end
        sh_next = 6'd32;
        for (int k = 31; k >= 0; k--)
            if (!cont[k])
                sh_next = 6'(k);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_valid_reg <= 1'b0;
            v1_valid_reg <= 1'b0;
            v2_valid_reg <= 1'b0;
        end
        else
        begin
            v0_valid_reg <= m2_valid_reg;
            v1_valid_reg <= v0_valid_reg;
            v2_valid_reg <= v1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        v0_spec_reg <= m2_spec_reg || ((m2_p1_reg == 0) && (m2_p2_reg == 0));
        v0_x_reg    <= neg_next ? -XW'(m2_p2_reg) : XW'(m2_p2_reg);
        v0_y_reg    <= neg_next ? -XW'(m2_p1_reg) : XW'(m2_p1_reg);
        v0_z_reg    <= neg_next ? HALF : '0;
        v1_spec_reg <= v0_spec_reg;
        v1_x_reg    <= v0_x_reg;
        v1_y_reg    <= v0_y_reg;
        v1_z_reg    <= v0_z_reg;
        v1_sh_reg   <= sh_next;
        v2_spec_reg <= v1_spec_reg;
        v2_x_reg    <= v1_x_reg <<< v1_sh_reg;
        v2_y_reg    <= v1_y_reg <<< v1_sh_reg;
        v2_z_reg    <= v1_z_reg;
    end

    // ---- vectoring chain: atan2 ----------------------------------------
    tag_t                 vt [S+1];
    logic signed [XW-1:0] vx [S+1];
    logic signed [XW-1:0] vy [S+1];
    logic signed [ZW-1:0] vz [S+1];

    assign vt[0] = '{valid: v2_valid_reg, flip: 1'b0, spec: v2_spec_reg};
    assign vx[0] = v2_x_reg;
    assign vy[0] = v2_y_reg;
    assign vz[0] = v2_z_reg;

    for (genvar i = 0; i < S; i++)
    begin : g_vec
        gcib_cordic_cell #(
            .FRAC_BITS(FRAC_BITS), .ZW(ZW), .STAGE(i), .VECTOR(1'b1)
        ) u_cell (
            .clk(clk), .rst_n(rst_n),
            .tag_in(vt[i]), .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
            .tag_out(vt[i+1]), .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1])
        );
    end

    // ---- output: into [0, 360), round to FRAC_BITS, wrap 360 to 0 -----
    logic                 f0_valid_reg, f0_spec_reg, done_reg;
    logic signed [ZW-1:0] f0_z_reg, zp_next, rnd_next;
    logic        [30:0]   bearing_reg;

    always_comb
    begin
        zp_next = (vz[S] < 0) ? vz[S] + FULL : vz[S];
        if (zp_next < 0)
            zp_next = '0;
        rnd_next = (f0_z_reg + RND) >>> GUARD_BITS;
        if (rnd_next >= FULL_OUT)
            rnd_next = rnd_next - FULL_OUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            f0_valid_reg <= vt[S].valid;
            done_reg     <= f0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f0_spec_reg <= vt[S].spec;
        f0_z_reg    <= zp_next;
        bearing_reg <= f0_spec_reg ? '0 : 31'(rnd_next);
    end

    assign done    = done_reg;
    assign bearing = bearing_reg;

endmodule

// ===== rtl/core/gcib_checker.sv =====
module gcib_checker #(
    parameter int FRAC_BITS    = gcib_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = gcib_pkg::CORDIC_STEPS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [30:0] bearing
);
    import gcib_pkg::*;

`include "great_circle_initial_bearing_assert.svh"

    localparam int LAT = 10 + 2 * CORDIC_STEPS;

    `GCIB_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy)
    `GCIB_ASSERT_DLY(a_latency, clk, rst_n, start && !busy, LAT, done)
    `GCIB_ASSERT_IMP(a_no_orphan, clk, rst_n, done, $past(start && !busy, LAT))
    `GCIB_ASSERT_IMP(a_range, clk, rst_n, done, longint'(bearing) < (longint'(360) << FRAC_BITS))

endmodule

bind great_circle_initial_bearing gcib_checker #(
    .FRAC_BITS(FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
) u_gcib_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .bearing(bearing)
);

// ===== test/bearing_checker.sv =====
`timescale 1ns / 100ps

module bearing_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [29:0] start_lat,
    input  logic signed [30:0] start_lon,
    input  logic signed [29:0] end_lat,
    input  logic signed [30:0] end_lon,
    input  logic               done,
    input  logic        [30:0] bearing,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);
    localparam int FRAC = 22;
    localparam int GUARD = 6;
    localparam int ANG = FRAC + GUARD;
    localparam int STEPS = 24;
    localparam longint unsigned BILLION = 64'd1000000000;

    logic [30:0] bearing_q[$];
    int mismatches;

    // atan(2^-i) in nano-degrees
    function automatic longint unsigned atan_ndeg(int i);
        case (i & 31)
            0: return 64'd45000000000;  1: return 64'd26565051177;
            2: return 64'd14036243468;  3: return 64'd7125016349;
            4: return 64'd3576334375;   5: return 64'd1789910608;
            6: return 64'd895173710;    7: return 64'd447614171;
            8: return 64'd223810500;    9: return 64'd111905677;
            10: return 64'd55952892;    11: return 64'd27976453;
            12: return 64'd13988227;    13: return 64'd6994114;
            14: return 64'd3497057;     15: return 64'd1748528;
            16: return 64'd874264;      17: return 64'd437132;
            18: return 64'd218566;      19: return 64'd109283;
            20: return 64'd54642;       21: return 64'd27321;
            22: return 64'd13660;       23: return 64'd6830;
            24: return 64'd3415;        25: return 64'd1708;
            26: return 64'd854;         27: return 64'd427;
            28: return 64'd213;         29: return 64'd107;
            30: return 64'd53;          default: return 64'd27;
        endcase
    endfunction

    function automatic longint angle_step(int i);
        longint unsigned n, q, r;
        n = atan_ndeg(i);
        q = n / BILLION;
        r = n % BILLION;
        return longint'((q << ANG) + ((r << ANG) + BILLION / 2) / BILLION);
    endfunction

    function automatic longint rmul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic void sin_cos(input longint a, output longint s, output longint c);
        longint full, x, y, z, dx, dy, da;
        bit flip;
        full = 64'sd360 <<< ANG;
        x = 652032874;
        y = 0;
        z = a % full;
        flip = 0;
        if (z < 0) z += full;
        if (z >= full / 2) z -= full;
        if (z > (64'sd90 <<< ANG)) begin z -= 64'sd180 <<< ANG; flip = 1; end
        else if (z < -(64'sd90 <<< ANG)) begin z += 64'sd180 <<< ANG; flip = 1; end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            da = angle_step(i);
            if (z >= 0) begin x -= dx; y += dy; z -= da; end
            else begin x += dx; y -= dy; z += da; end
        end
        if (flip) begin x = -x; y = -y; end
        s = y;
        c = x;
    endfunction

    function automatic longint heading_angle(longint y, longint x);
        longint z, dx, dy, da, lim;
        int n;
        lim = 64'sd1 <<< 29;
        z = 0;
        n = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin x = -x; y = -y; z = 64'sd180 <<< ANG; end
        while (n < 32 && x < lim && y < lim && y > -lim)
        begin
            x *= 2; y *= 2; n++;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            da = angle_step(i);
            if (y >= 0) begin x += dx; y -= dy; z += da; end
            else begin x -= dx; y += dy; z -= da; end
        end
        if (z < 0) z += 64'sd360 <<< ANG;
        if (z < 0) z = 0;
        return z;
    endfunction

    function automatic logic [30:0] predict_bearing(longint lat1, longint lon1,
                                                     longint lat2, longint lon2);
        longint s1, c1, s2, c2, sd, cd, z;
        longint unsigned r;
        if (lat1 == lat2 && lon1 == lon2) return '0;
        sin_cos(lat1 * 64, s1, c1);
        sin_cos(lat2 * 64, s2, c2);
        sin_cos((lon2 - lon1) * 64, sd, cd);
        z = heading_angle(rmul(sd, c2), rmul(c1, s2) - rmul(rmul(s1, c2), cd));
        r = z;
        r = (r + 64'd32) >> GUARD;
        if (r >= (64'd360 << FRAC)) r -= 64'd360 << FRAC;
        return r[30:0];
    endfunction

    assign pending = bearing_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [30:0] want;
        if (!rst_n)
        begin
            fail_count <= 0;
            mismatches = 0;
            result_count <= 0;
            bearing_q.delete();
        end
        else
        begin
            if (start && !busy)
                bearing_q.push_back(predict_bearing(longint'(start_lat), longint'(start_lon),
                                                    longint'(end_lat), longint'(end_lon)));
            if (done)
            begin
                result_count <= result_count + 1;
                if (bearing_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (mismatches < 10)
                        $display("unexpected bearing %0d", bearing);
                    mismatches++;
                end
                else
                begin
                    want = bearing_q.pop_front();
                    if (want !== bearing)
                    begin
                        fail_count <= fail_count + 1;
                        if (mismatches < 10)
                            $display("bearing mismatch: expected %0d got %0d", want, bearing);
                        mismatches++;
                    end
                end
            end
        end
    end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    localparam int LAT_MAX = 377487360;
    localparam int LON_MAX = 754974720;
    localparam int DEG = 1 << 22;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy, done;
    logic signed [29:0] start_lat = '0, end_lat = '0;
    logic signed [30:0] start_lon = '0, end_lon = '0;
    logic [30:0] bearing;
    int fail_count, pending, result_count;
    int idle_pct;
    int sent;

    great_circle_initial_bearing dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .start_lat(start_lat), .start_lon(start_lon),
        .end_lat(end_lat), .end_lon(end_lon),
        .done(done), .bearing(bearing)
    );

    bearing_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .start_lat(start_lat), .start_lon(start_lon),
        .end_lat(end_lat), .end_lon(end_lon),
        .done(done), .bearing(bearing),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // Each request is held until taken (start high, busy low); random gaps
    // of idle_pct percent are inserted between requests.
    task automatic send_request(input int la1, input int lo1, input int la2, input int lo2);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        start_lat <= 30'(la1);
        start_lon <= 31'(lo1);
        end_lat <= 30'(la2);
        end_lon <= 31'(lo2);
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
    endtask

    function automatic int pick_lat();
        case ($urandom_range(5))
            0: return $urandom_range(2 * LAT_MAX) - LAT_MAX;  // full range
            1: return $urandom_range(180 * DEG) - 90 * DEG;     // valid latitudes
            2: return ($urandom_range(4) - 2) * 45 * DEG;        // landmarks
            3: return $urandom_range(7) - 4;                     // near zero
            4: return ($urandom_range(1) ? 1 : -1) * (90 * DEG - $urandom_range(3));
            default: return $urandom_range(2 * LAT_MAX) - LAT_MAX;
        endcase
    endfunction

    function automatic int pick_lon();
        case ($urandom_range(4))
            0: return $urandom_range(2 * LON_MAX) - LON_MAX;
            1: return $urandom_range(360 * DEG) - 180 * DEG;
            2: return ($urandom_range(8) - 4) * 45 * DEG;
            3: return $urandom_range(7) - 4;
            default: return $urandom_range(2 * LON_MAX) - LON_MAX;
        endcase
    endfunction

    task automatic random_phase(input int pct, input int count);
        int la1, lo1, la2, lo2;
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            la1 = pick_lat();
            lo1 = pick_lon();
            la2 = pick_lat();
            lo2 = pick_lon();
            case ($urandom_range(9))
                0: begin la2 = la1; lo2 = lo1; end          // same point
                1: lo2 = lo1;                               // due north/south
                2: la2 = la1;                               // same parallel
                3: lo2 = lo1 + ($urandom_range(1) ? 180 : -180) * DEG; // antipodal meridian
                4: begin la2 = la1 + $urandom_range(3) - 1; lo2 = lo1 + $urandom_range(3) - 1; end
                default: ;
            endcase
            if (la2 > LAT_MAX) la2 = LAT_MAX;
            if (la2 < -LAT_MAX) la2 = -LAT_MAX;
            if (lo2 > LON_MAX) lo2 = LON_MAX;
            if (lo2 < -LON_MAX) lo2 = -LON_MAX;
            send_request(la1, lo1, la2, lo2);
            // a short burst with no idling now and then
            if ($urandom_range(49) == 0) idle_pct = 0;
            else if ($urandom_range(49) == 0) idle_pct = pct;
        end
        start <= 0;
    endtask

    initial
    begin
        sent = 0;
        idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: field extremes, coincident points, poles, wraps
        send_request(0, 0, 0, 0);
        send_request(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
        send_request(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_request(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
        send_request(-LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
        send_request(0, 0, 0, 1);
        send_request(0, 0, 1, 0);
        send_request(0, 0, -1, 0);
        send_request(0, 0, 0, -1);
        send_request(0, 0, 0, 180 * DEG);
        send_request(0, 0, 0, -180 * DEG);
        send_request(90 * DEG, 0, 0, 0);
        send_request(-90 * DEG, 0, 0, 0);
        send_request(0, 0, 90 * DEG, 0);
        send_request(45 * DEG, 10 * DEG, -45 * DEG, -170 * DEG);
        send_request(0, -1, 0, 0);
        send_request(-1, 0, 0, 0);
        send_request(30 * DEG, 0, 30 * DEG, 90 * DEG);
        send_request(120 * DEG, 0, -100 * DEG, 5 * DEG);
        send_request(-LAT_MAX, 0, 0, LON_MAX);
        send_request(12345, -LON_MAX, -12345, LON_MAX);
        send_request(-1, -1, -1, -1);
        start <= 0;

        random_phase(0, 330);
        random_phase(52, 320);
        random_phase(0, 320);
        random_phase(32, 330);

        while (pending > 0) @(posedge clk);
        repeat (80) @(posedge clk);
        $display("Sent %0d coordinate requests, %0d bearings checked,", sent, result_count);
        $display("idle phases of 0/52/32 percent, pole, wrap and same-point cases.");
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/gcib_pkg.sv
rtl/core/gcib_cordic_cell.sv
rtl/core/great_circle_initial_bearing.sv
rtl/core/gcib_checker.sv
test/bearing_checker.sv
test/testbench.sv
